>>> hdl/btnlock_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnlock_pkg
// Shared types and constants of the button unlock sequencer: register map,
// reset values, remote command codes and LED duty levels.
// ----------------------------------------------------------------------------
package btnlock_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // Register map, register index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_HOLD       = 3'd0,
    REG_REL_WINDOW = 3'd1,
    REG_SETTLE     = 3'd2,
    REG_ACK_WINDOW = 3'd3,
    REG_UNLOCK     = 3'd4,
    REG_DEBOUNCE   = 3'd5
  } reg_idx_e;

  localparam logic [15:0] HoldRst      = 16'd1000;
  localparam logic [15:0] RelWindowRst = 16'd2000;
  localparam logic [15:0] SettleRst    = 16'd1000;
  localparam logic [15:0] AckWindowRst = 16'd2000;
  localparam logic [23:0] UnlockRst    = 24'd10000;
  localparam logic [15:0] DebounceRst  = 16'd250;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_OFF   = 2'd1,
    CMD_ON    = 2'd2,
    CMD_SPARE = 2'd3
  } remote_cmd_e;

  localparam logic [9:0] LedDim  = 10'd5;
  localparam logic [9:0] LedHold = 10'd511;
  localparam logic [9:0] LedOn   = 10'd255;
  localparam logic [9:0] LedFull = 10'd1023;

endpackage

>>> hdl/btnlock_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btnlock_if
// Request and result channels of the button unlock sequencer (valid/ready).
// ----------------------------------------------------------------------------
interface btnlock_in_if;
  logic       valid;
  logic       ready;
  logic       button_down;
  logic [1:0] remote_cmd;

  modport source (output valid, output button_down, output remote_cmd, input ready);
  modport sink   (input valid, input button_down, input remote_cmd, output ready);
endinterface

interface btnlock_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] lock_state;
  logic [9:0] led_level;
  logic       power_request;

  modport source (output valid, output lock_state, output led_level,
                  output power_request, input ready);
  modport sink   (input valid, input lock_state, input led_level,
                  input power_request, output ready);
endinterface

>>> hdl/button_unlock_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_unlock_sequencer
// Push-button key lock with LED feedback and a togglable power request.
// ----------------------------------------------------------------------------
// Each request is one millisecond tick (button level plus remote command) and
// yields exactly one result: lock state, LED duty and power request after the
// tick. One request per clock cycle is taken while the result sink keeps up;
// the result appears in the cycle after acceptance, straight from the state
// registers, the only stage. A waiting result does not stop the next request
// once the sink takes it in the same cycle. The user must write configuration
// over APB while no tick is in flight (not enforced); registers read back.
// ----------------------------------------------------------------------------
module button_unlock_sequencer #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  btnlock_in_if.sink                     tick_i,
  btnlock_out_if.source                  result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btnlock_pkg::AddrW-1:0]  paddr,
  input  logic [btnlock_pkg::DataW-1:0]  pwdata,
  output logic [btnlock_pkg::DataW-1:0]  prdata,
  output logic                           pready
);

  localparam int unsigned CmpW = (TIMER_WIDTH > 24) ? TIMER_WIDTH : 24;
  localparam logic [TIMER_WIDTH-1:0] TMax = '1;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_HOLD      = 3'd1,
    ST_WAIT_REL  = 3'd2,
    ST_SETTLE    = 3'd3,
    ST_WAIT_ACK  = 3'd4,
    ST_UNLOCKED  = 3'd5,
    ST_LOCK_WAIT = 3'd6
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] hold_q, rel_window_q, settle_q, ack_window_q, debounce_q;
  logic [23:0] unlock_q;
  logic        wr_en;
  btnlock_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = btnlock_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q       <= btnlock_pkg::HoldRst;
      rel_window_q <= btnlock_pkg::RelWindowRst;
      settle_q     <= btnlock_pkg::SettleRst;
      ack_window_q <= btnlock_pkg::AckWindowRst;
      unlock_q     <= btnlock_pkg::UnlockRst;
      debounce_q   <= btnlock_pkg::DebounceRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        btnlock_pkg::REG_HOLD:       hold_q       <= pwdata[15:0];
        btnlock_pkg::REG_REL_WINDOW: rel_window_q <= pwdata[15:0];
        btnlock_pkg::REG_SETTLE:     settle_q     <= pwdata[15:0];
        btnlock_pkg::REG_ACK_WINDOW: ack_window_q <= pwdata[15:0];
        btnlock_pkg::REG_UNLOCK:     unlock_q     <= pwdata[23:0];
        btnlock_pkg::REG_DEBOUNCE:   debounce_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      btnlock_pkg::REG_HOLD:       prdata = {16'd0, hold_q};
      btnlock_pkg::REG_REL_WINDOW: prdata = {16'd0, rel_window_q};
      btnlock_pkg::REG_SETTLE:     prdata = {16'd0, settle_q};
      btnlock_pkg::REG_ACK_WINDOW: prdata = {16'd0, ack_window_q};
      btnlock_pkg::REG_UNLOCK:     prdata = {8'd0, unlock_q};
      btnlock_pkg::REG_DEBOUNCE:   prdata = {16'd0, debounce_q};
      default:                     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tick processing
  // --------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [TIMER_WIDTH-1:0] since_press_q, since_press_d;
  logic [TIMER_WIDTH-1:0] since_rel_q, since_rel_d;
  logic                   button_q, request_q, request_d;
  logic [9:0]             led_q, led_d;
  logic                   out_valid_q, out_valid_d;

  logic                   accept, pressed, press_edge, rel_edge;
  btnlock_pkg::remote_cmd_e cmd;
  logic [CmpW-1:0]        sp_ext, sr_ext;

  assign tick_i.ready = ~out_valid_q | result_o.ready;
  assign accept       = tick_i.valid & tick_i.ready;
  assign pressed      = tick_i.button_down;
  assign cmd          = btnlock_pkg::remote_cmd_e'(tick_i.remote_cmd);
  assign press_edge   = pressed & ~button_q;
  assign rel_edge     = ~pressed & button_q;

  always_comb begin
    since_press_d = press_edge ? '0 :
                    (since_press_q == TMax) ? TMax : since_press_q + TIMER_WIDTH'(1);
    since_rel_d   = rel_edge ? '0 :
                    (since_rel_q == TMax) ? TMax : since_rel_q + TIMER_WIDTH'(1);
    sp_ext = CmpW'(since_press_d);
    sr_ext = CmpW'(since_rel_d);

    state_d = state_q;
    led_d   = led_q;
    // LED follows the state held before the step
    unique case (state_q)
      ST_LOCK_WAIT: begin
        if (!pressed) state_d = ST_IDLE;
      end
      ST_HOLD: begin
        led_d = btnlock_pkg::LedHold;
        if (!pressed) state_d = ST_IDLE;
        else if (sp_ext >= CmpW'(hold_q)) state_d = ST_WAIT_REL;
      end
      ST_WAIT_REL: begin
        led_d = btnlock_pkg::LedDim;
        if (!pressed) state_d = ST_SETTLE;
        else if (sp_ext >= CmpW'(rel_window_q)) state_d = ST_LOCK_WAIT;
      end
      ST_SETTLE: begin
        if (pressed) state_d = ST_LOCK_WAIT;
        else if (sr_ext >= CmpW'(settle_q)) state_d = ST_WAIT_ACK;
      end
      ST_WAIT_ACK: begin
        led_d = btnlock_pkg::LedFull;
        if (pressed) state_d = ST_UNLOCKED;
        else if (sr_ext >= CmpW'(ack_window_q)) state_d = ST_IDLE;
      end
      ST_UNLOCKED: begin
        led_d = pressed ? btnlock_pkg::LedFull :
                request_q ? btnlock_pkg::LedOn : btnlock_pkg::LedDim;
        if (sr_ext >= CmpW'(unlock_q) && sp_ext >= CmpW'(unlock_q))
          state_d = ST_LOCK_WAIT;
      end
      default: begin
        led_d   = btnlock_pkg::LedDim;
        state_d = pressed ? ST_HOLD : ST_IDLE;
      end
    endcase

    // debounced press toggles; a press that fails is swallowed
    request_d = request_q;
    if (press_edge && state_d == ST_UNLOCKED && sr_ext > CmpW'(debounce_q))
      request_d = ~request_q;

    unique case (cmd)
      btnlock_pkg::CMD_OFF: request_d = 1'b0;
      btnlock_pkg::CMD_ON:  request_d = 1'b1;
      default: ;
    endcase

    out_valid_d = accept | (out_valid_q & ~result_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      since_press_q <= '0;
      since_rel_q   <= '0;
      button_q      <= 1'b0;
      request_q     <= 1'b0;
      led_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q       <= state_d;
        since_press_q <= since_press_d;
        since_rel_q   <= since_rel_d;
        button_q      <= pressed;
        request_q     <= request_d;
        led_q         <= led_d;
      end
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.lock_state    = state_q;
  assign result_o.led_level     = led_q;
  assign result_o.power_request = request_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_req_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(request_q))
    else $error("power request changed without a tick");

  a_result_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted tick produced no result");

  a_unlock_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && state_q == ST_UNLOCKED) |=>
      (state_q == ST_UNLOCKED || state_q == ST_LOCK_WAIT))
    else $error("unlocked state left by an illegal path");

  a_press_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && press_edge) |=> (since_press_q == '0 && button_q))
    else $error("press edge did not restart the press timer");

endmodule

>>> bench/tb_button_unlock_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_unlock_sequencer
// Self-checking bench for the push-button key lock. Millisecond ticks are
// driven as valid/ready requests. A scoreboard class models the lock, the
// elapsed-time counters, the LED duty and the power request, and compares
// every result with its prediction. Timing registers are set over APB and
// read back between phases: short windows for most phases, plus zero, minimum
// and maximum settings. Both handshake sides stall at random but in one phase.
// ----------------------------------------------------------------------------
module tb_button_unlock_sequencer;

  localparam int unsigned TimerW = 24;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_HOLD       = 3'd1,
    ST_AWAIT_REL  = 3'd2,
    ST_SETTLE     = 3'd3,
    ST_AWAIT_ACK  = 3'd4,
    ST_UNLOCKED   = 3'd5,
    ST_LOCKED_REL = 3'd6
  } lock_state_e;

  typedef struct packed {
    lock_state_e state;
    logic [9:0]  led;
    logic        power;
  } lock_result_t;

  class unlock_scoreboard;
    logic [15:0]       hold_ms, rel_window_ms, settle_ms, ack_window_ms, debounce_ms;
    logic [23:0]       unlock_ms;
    lock_state_e       state;
    logic [TimerW-1:0] since_press, since_release;
    logic              button_prev, power_req;
    logic [9:0]        led;
    lock_result_t      pending_q[$];
    int unsigned       errors;

    function new();
      hold_ms       = btnlock_pkg::HoldRst;
      rel_window_ms = btnlock_pkg::RelWindowRst;
      settle_ms     = btnlock_pkg::SettleRst;
      ack_window_ms = btnlock_pkg::AckWindowRst;
      unlock_ms     = btnlock_pkg::UnlockRst;
      debounce_ms   = btnlock_pkg::DebounceRst;
      state         = ST_IDLE;
      since_press   = '0;
      since_release = '0;
      button_prev   = 1'b0;
      power_req     = 1'b0;
      led           = '0;
      errors        = 0;
    endfunction

    function void set_reg(btnlock_pkg::reg_idx_e idx, logic [31:0] value);
      case (idx)
        btnlock_pkg::REG_HOLD:       hold_ms       = value[15:0];
        btnlock_pkg::REG_REL_WINDOW: rel_window_ms = value[15:0];
        btnlock_pkg::REG_SETTLE:     settle_ms     = value[15:0];
        btnlock_pkg::REG_ACK_WINDOW: ack_window_ms = value[15:0];
        btnlock_pkg::REG_UNLOCK:     unlock_ms     = value[23:0];
        btnlock_pkg::REG_DEBOUNCE:   debounce_ms   = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [TimerW-1:0] sat_inc(logic [TimerW-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // Predict the result of one accepted tick request
    function void note_tick(logic pressed, btnlock_pkg::remote_cmd_e cmd);
      logic         press_edge, release_edge;
      lock_result_t res;
      press_edge    = pressed && !button_prev;
      release_edge  = !pressed && button_prev;
      since_press   = press_edge ? '0 : sat_inc(since_press);
      since_release = release_edge ? '0 : sat_inc(since_release);
      button_prev   = pressed;

      // LED follows the state held before the step
      case (state)
        ST_LOCKED_REL: if (!pressed) state = ST_IDLE;
        ST_HOLD: begin
          led = btnlock_pkg::LedHold;
          if (!pressed) state = ST_IDLE;
          else if (since_press >= hold_ms) state = ST_AWAIT_REL;
        end
        ST_AWAIT_REL: begin
          led = btnlock_pkg::LedDim;
          if (!pressed) state = ST_SETTLE;
          else if (since_press >= rel_window_ms) state = ST_LOCKED_REL;
        end
        ST_SETTLE: begin
          if (pressed) state = ST_LOCKED_REL;
          else if (since_release >= settle_ms) state = ST_AWAIT_ACK;
        end
        ST_AWAIT_ACK: begin
          led = btnlock_pkg::LedFull;
          if (pressed) state = ST_UNLOCKED;
          else if (since_release >= ack_window_ms) state = ST_IDLE;
        end
        ST_UNLOCKED: begin
          led = pressed ? btnlock_pkg::LedFull :
                (power_req ? btnlock_pkg::LedOn : btnlock_pkg::LedDim);
          if (since_release >= unlock_ms && since_press >= unlock_ms) state = ST_LOCKED_REL;
        end
        default: begin
          led   = btnlock_pkg::LedDim;
          state = pressed ? ST_HOLD : ST_IDLE;
        end
      endcase

      // the acknowledging press may toggle too; a bouncy press is swallowed
      if (press_edge && state == ST_UNLOCKED && since_release > debounce_ms)
        power_req = !power_req;

      if (cmd == btnlock_pkg::CMD_OFF) power_req = 1'b0;
      else if (cmd == btnlock_pkg::CMD_ON) power_req = 1'b1;

      res.state = state;
      res.led   = led;
      res.power = power_req;
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [2:0] st, logic [9:0] led_act, logic power_act);
      lock_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: state %0d led %0d power %0b",
                 $time, st, led_act, power_act);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (st !== want.state) begin
        $display("%0t: lock_state expected %0d actual %0d", $time, want.state, st);
        errors++;
      end
      if (led_act !== want.led) begin
        $display("%0t: led_level expected %0d actual %0d", $time, want.led, led_act);
        errors++;
      end
      if (power_act !== want.power) begin
        $display("%0t: power_request expected %0b actual %0b", $time, want.power, power_act);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel, penable, pwrite, pready;
  logic [btnlock_pkg::AddrW-1:0] paddr;
  logic [btnlock_pkg::DataW-1:0] pwdata, prdata;

  btnlock_in_if  tick_bus ();
  btnlock_out_if result_bus ();

  button_unlock_sequencer dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  unlock_scoreboard sb;
  int unsigned      ticks_sent;
  int unsigned      cfg_errors;
  bit               steady;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    result_bus.ready <= steady || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid === 1'b1 && result_bus.ready)
      sb.check_result(result_bus.lock_state, result_bus.led_level, result_bus.power_request);
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic btnlock_pkg::remote_cmd_e rand_cmd();
    if (chance(85)) return btnlock_pkg::CMD_NONE;
    return btnlock_pkg::remote_cmd_e'($urandom_range(1, 3));
  endfunction

  task automatic send_tick(input logic pressed, input btnlock_pkg::remote_cmd_e cmd);
    @(negedge clk_i);
    while (!steady && chance(13)) begin
      tick_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_bus.valid       <= 1'b1;
    tick_bus.button_down <= pressed;
    tick_bus.remote_cmd  <= cmd;
    @(posedge clk_i);
    while (!tick_bus.ready) @(posedge clk_i);
    sb.note_tick(pressed, cmd);
    ticks_sent++;
  endtask

  // hold the button level for n ticks (at least one)
  task automatic run_level(input logic pressed, input int unsigned n);
    repeat ((n == 0) ? 1 : n) send_tick(pressed, rand_cmd());
  endtask

  task automatic noise_burst(input int unsigned n);
    repeat (n) send_tick(1'($urandom_range(0, 1)),
                         btnlock_pkg::remote_cmd_e'($urandom_range(0, 3)));
  endtask

  // lower valid and let every outstanding result drain
  task automatic wait_idle();
    @(negedge clk_i);
    tick_bus.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input btnlock_pkg::reg_idx_e idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == btnlock_pkg::REG_UNLOCK) ? 32'h00FF_FFFF : 32'h0000_FFFF;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, value);
    // read back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if ((prdata & mask) !== (value & mask)) begin
      $display("%0t: register %0d read back expected %0d actual %0d",
               $time, idx, value & mask, prdata & mask);
      cfg_errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timing(input int unsigned h, input int unsigned rw, input int unsigned s,
                            input int unsigned aw, input int unsigned u, input int unsigned d);
    wait_idle();
    cfg_write(btnlock_pkg::REG_HOLD, h);
    cfg_write(btnlock_pkg::REG_REL_WINDOW, rw);
    cfg_write(btnlock_pkg::REG_SETTLE, s);
    cfg_write(btnlock_pkg::REG_ACK_WINDOW, aw);
    cfg_write(btnlock_pkg::REG_UNLOCK, u);
    cfg_write(btnlock_pkg::REG_DEBOUNCE, d);
  endtask

  // Mostly a proper hold / release / settle / acknowledge walk with timings
  // around each threshold, then a few toggles once unlocked
  task automatic unlock_attempt();
    int unsigned h, rw, s, aw, u, d, len, k;
    h  = 32'(sb.hold_ms);
    rw = 32'(sb.rel_window_ms);
    s  = 32'(sb.settle_ms);
    aw = 32'(sb.ack_window_ms);
    u  = 32'(sb.unlock_ms);
    d  = 32'(sb.debounce_ms);
    run_level(1'b0, $urandom_range(1, 3));
    len = chance(85) ? h + $urandom_range(0, 2) : rw + $urandom_range(0, 2);
    run_level(1'b1, len);
    len = chance(85) ? s + $urandom_range(0, 2) : $urandom_range(1, s + aw + 2);
    run_level(1'b0, len);
    run_level(1'b1, $urandom_range(1, 4));
    k = (d > 1000) ? 1 : $urandom_range(1, 5);
    repeat (k) begin
      len = chance(75) ? d + $urandom_range(0, 2) : $urandom_range(1, d + 1);
      run_level(1'b0, len);
      run_level(1'b1, $urandom_range(1, 3));
    end
    if (u <= 1000 && chance(50)) run_level(1'b0, u + $urandom_range(0, 3));
  endtask

  task automatic run_phase(input int unsigned h, input int unsigned rw, input int unsigned s,
                           input int unsigned aw, input int unsigned u, input int unsigned d,
                           input int unsigned n_ticks);
    int unsigned start;
    set_timing(h, rw, s, aw, u, d);
    start = ticks_sent;
    while (ticks_sent - start < n_ticks) begin
      if (chance(80)) unlock_attempt();
      else noise_burst($urandom_range(5, 10));
    end
  endtask

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [15:0] zero_pat;
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    tick_bus.valid       = 1'b0;
    tick_bus.button_down = 1'b0;
    tick_bus.remote_cmd  = btnlock_pkg::CMD_NONE;
    result_bus.ready     = 1'b0;
    steady               = 1'b0;
    ticks_sent           = 0;
    cfg_errors           = 0;
    sb                   = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset timings: every remote code, the spare one ignored
    send_tick(1'b0, btnlock_pkg::CMD_NONE);
    send_tick(1'b1, btnlock_pkg::CMD_ON);
    send_tick(1'b1, btnlock_pkg::CMD_SPARE);
    send_tick(1'b1, btnlock_pkg::CMD_OFF);
    send_tick(1'b0, btnlock_pkg::CMD_ON);
    send_tick(1'b0, btnlock_pkg::CMD_SPARE);
    send_tick(1'b0, btnlock_pkg::CMD_OFF);
    send_tick(1'b1, btnlock_pkg::CMD_NONE);
    send_tick(1'b0, btnlock_pkg::CMD_NONE);

    // zero timings: each step ends on its first tick
    set_timing(0, 0, 0, 0, 0, 0);
    zero_pat = 16'b0110_1011_0011_0110;
    for (int i = 0; i < 16; i++) send_tick(zero_pat[i], rand_cmd());

    run_phase(1, 1, 1, 1, 1, 0, 150);
    run_phase(3, 8, 2, 5, 20, 2, 150);
    steady = 1'b1;
    run_phase(5, 6, 4, 3, 30, 6, 150);
    steady = 1'b0;
    run_phase(2, 12, 3, 10, 15, 0, 150);
    // maximum timings: a short burst only, no window can close
    set_timing(65535, 65535, 65535, 65535, 24'hFF_FFFF, 65535);
    noise_burst(20);
    repeat (3) begin
      run_phase($urandom_range(1, 12), $urandom_range(1, 16), $urandom_range(1, 10),
                $urandom_range(1, 12), $urandom_range(4, 40), $urandom_range(0, 10), 150);
    end

    wait_idle();
    if (sb.errors == 0 && cfg_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> button_unlock_sequencer.f
hdl/btnlock_pkg.sv
hdl/btnlock_if.sv
hdl/button_unlock_sequencer.sv
bench/tb_button_unlock_sequencer.sv
